/* rtl/core/svt_pkg.sv */
// ----------------------------------------------------------------------------
// svt_pkg: shared types and constants of the sorted value table
// Sizes, request and status codes, cell commands and the word types of
// the request and result ports.
// ----------------------------------------------------------------------------
package svt_pkg;

  // table size and derived widths
  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int GROUP  = 8;
  localparam int NGROUP = (DEPTH + GROUP - 1) / GROUP;

  typedef logic signed [31:0] value_t;
  typedef logic [CNT_W-1:0]   count_t;

  typedef enum logic [1:0] {
    REQ_INSERT     = 2'd0,
    REQ_REMOVE_ONE = 2'd1,
    REQ_REMOVE_ALL = 2'd2,
    REQ_READ       = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  // what every cell does in a given cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_cmd_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] value;
    logic [5:0]         position;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [6:0]         removed_count;
    logic [6:0]         entry_count;
    logic signed [31:0] smallest;
    logic signed [31:0] largest;
  } result_t;

  // count to the 7-bit result field, zero-extended or masked
  function automatic logic [6:0] to_field7(input count_t c);
    logic [CNT_W+6:0] w;
    w = (CNT_W + 7)'(c);
    return w[6:0];
  endfunction

endpackage

/* rtl/core/svt_cell.sv */
// ----------------------------------------------------------------------------
// svt_cell: one slot of the sorted row
// Holds one value and its valid bit, compares it with the request value
// and takes its left or right neighbor's entry when the row shifts.
// ----------------------------------------------------------------------------
module svt_cell (
  input  logic               clk,
  input  logic               rst,
  input  svt_pkg::cell_cmd_e cmd,
  input  svt_pkg::value_t    val,
  input  svt_pkg::value_t    left_entry,
  input  logic               left_valid,
  input  logic               left_lt,
  input  svt_pkg::value_t    right_entry,
  input  logic               right_valid,
  output svt_pkg::value_t    entry,
  output logic               valid,
  output logic               lt,
  output logic               eq
);
  import svt_pkg::*;

  assign lt = valid && (entry < val);
  assign eq = valid && (entry == val);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      unique case (cmd)
        CELL_INSERT: begin
          // cells past the insert point move one place up
          if (!lt) begin
            entry <= left_lt ? val : left_entry;
            valid <= left_lt ? 1'b1 : left_valid;
          end
        end
        CELL_SHIFT: begin
          // cells from the match on close the gap
          if (!lt) begin
            entry <= right_entry;
            valid <= right_valid;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/core/svt_reduce.sv */
// ----------------------------------------------------------------------------
// svt_reduce: select tree over the cell row
// Picks the one selected entry out of the row through a registered
// group stage and a final or of the group results.
// ----------------------------------------------------------------------------
module svt_reduce (
  input  logic            clk,
  input  svt_pkg::value_t vals [svt_pkg::DEPTH],
  input  logic            sel  [svt_pkg::DEPTH],
  output svt_pkg::value_t pick
);
  import svt_pkg::*;

  value_t grp [NGROUP];

  for (genvar g = 0; g < NGROUP; g++) begin : g_grp
    value_t acc;
    always_comb begin
      acc = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < DEPTH) begin
          if (sel[g * GROUP + k]) acc = acc | vals[g * GROUP + k];
        end
      end
    end
    always_ff @(posedge clk) begin
      grp[g] <= acc;
    end
  end

  always_comb begin
    pick = '0;
    for (int g = 0; g < NGROUP; g++) begin
      pick = pick | grp[g];
    end
  end

endmodule

/* rtl/core/sorted_value_table.sv */
// ----------------------------------------------------------------------------
// sorted_value_table: sorted table of signed 32-bit values
// Keeps up to DEPTH values in ascending order in a row of compare cells;
// inserts, removes one or all copies of a value, and reads by position.
// ----------------------------------------------------------------------------
//
//   channel   handshake            word       notes
//   -------   ------------------   --------   ------------------------------
//   request   start, busy          request    taken when start && !busy
//   result    done                 result     one-cycle strobe, no stall
//
// insert, remove one and read pass through S_OP, S_GATHER and S_REPORT and
// end with done as the block goes back to idle; busy is high meanwhile
// remove all stays in S_OP while a copy is still found, since the cell
// row closes one gap per cycle
// read value and largest entry come out of a two-level select tree over the cell row
// reset empties the table at once; no clearing pass, entries are untouched
// the receiver cannot stall: done is a one-cycle strobe
// ----------------------------------------------------------------------------
module sorted_value_table (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  svt_pkg::req_t    request,
  output logic             done,
  output svt_pkg::result_t result
);
  import svt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_OP,
    S_GATHER,
    S_REPORT
  } state_t;

  state_t    state;
  req_t      req;        // request held for the whole operation
  count_t    count;      // stored entries
  count_t    removed;    // entries removed by this request
  status_e   status;
  cell_cmd_e cmd;

  // cell row
  value_t entry [DEPTH];
  logic   valid [DEPTH];
  logic   lt    [DEPTH];
  logic   eq    [DEPTH];
  logic   sel_read [DEPTH];
  logic   sel_last [DEPTH];

  logic   found;
  logic   full;
  logic   in_range;
  value_t read_pick;
  value_t last_pick;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    value_t l_entry;
    logic   l_valid;
    logic   l_lt;
    value_t r_entry;
    logic   r_valid;

    if (i == 0) begin : g_first
      // the head sees the new value as its left neighbor
      assign l_entry = req.value;
      assign l_valid = 1'b1;
      assign l_lt    = 1'b0;
    end else begin : g_mid
      assign l_entry = entry[i-1];
      assign l_valid = valid[i-1];
      assign l_lt    = lt[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_entry = entry[i];
      assign r_valid = 1'b0;
      assign sel_last[i] = valid[i];
    end else begin : g_inner
      assign r_entry = entry[i+1];
      assign r_valid = valid[i+1];
      assign sel_last[i] = valid[i] && !valid[i+1];
    end

    // position compare against this slot's fixed index
    assign sel_read[i] = valid[i] &&
                         ((IDX_W + 6)'(req.position) == (IDX_W + 6)'(i));

    svt_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .val         (req.value),
      .left_entry  (l_entry),
      .left_valid  (l_valid),
      .left_lt     (l_lt),
      .right_entry (r_entry),
      .right_valid (r_valid),
      .entry       (entry[i]),
      .valid       (valid[i]),
      .lt          (lt[i]),
      .eq          (eq[i])
    );
  end

  // any match will do: equal entries sit next to each other
  always_comb begin
    found = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      found = found | eq[i];
    end
  end

  assign full     = (count == CNT_W'(DEPTH));
  assign in_range = (CNT_W + 6)'(req.position) < (CNT_W + 6)'(count);
  assign busy     = (state != S_IDLE);

  // row command, only in the operate state
  always_comb begin
    cmd = CELL_HOLD;
    if (state == S_OP) begin
      unique case (req.req_type)
        REQ_INSERT:     cmd = full ? CELL_HOLD : CELL_INSERT;
        REQ_REMOVE_ONE,
        REQ_REMOVE_ALL: cmd = found ? CELL_SHIFT : CELL_HOLD;
        default:        cmd = CELL_HOLD;
      endcase
    end
  end

  svt_reduce u_read_sel (
    .clk  (clk),
    .vals (entry),
    .sel  (sel_read),
    .pick (read_pick)
  );

  svt_reduce u_last_sel (
    .clk  (clk),
    .vals (entry),
    .sel  (sel_last),
    .pick (last_pick)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      removed <= '0;
      status  <= ST_OK;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req     <= request;
            removed <= '0;
            status  <= ST_OK;
            state   <= S_OP;
          end
        end
        S_OP: begin
          unique case (req.req_type)
            REQ_INSERT: begin
              if (full) begin
                status <= ST_FULL;
              end else begin
                count <= count + 1'b1;
              end
              state <= S_GATHER;
            end
            REQ_REMOVE_ONE: begin
              if (found) begin
                count   <= count - 1'b1;
                removed <= count_t'(1);
              end else begin
                status <= ST_NOT_FOUND;
              end
              state <= S_GATHER;
            end
            REQ_REMOVE_ALL: begin
              // one copy leaves per cycle until none is left
              if (found) begin
                count   <= count - 1'b1;
                removed <= removed + 1'b1;
              end else begin
                if (removed == '0) status <= ST_NOT_FOUND;
                state <= S_GATHER;
              end
            end
            default: begin
              if (!in_range) status <= ST_RANGE;
              state <= S_GATHER;
            end
          endcase
        end
        S_GATHER: begin
          // select tree captures the settled row
          state <= S_REPORT;
        end
        S_REPORT: begin
          done                 <= 1'b1;
          result.status        <= status;
          result.read_value    <= (req.req_type == REQ_READ && status == ST_OK) ?
                                  read_pick : '0;
          result.removed_count <= to_field7(removed);
          result.entry_count   <= to_field7(count);
          result.smallest      <= (count != '0) ? entry[0] : '0;
          result.largest       <= (count != '0) ? last_pick : '0;
          state                <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/svt_checker.sv */
// ----------------------------------------------------------------------------
// svt_checker: port-level checks of the sorted value table
// Watches the handshake and result ports and flags words that break the
// block's sequencing or report inconsistent table summaries.
// ----------------------------------------------------------------------------
module svt_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input svt_pkg::result_t result
);
  import svt_pkg::*;

  // an accepted word keeps the block busy the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accept did not raise busy");

  // results never come back to back
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two result words in a row");

  // a result is shown only once the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while busy");

  // empty table reports zero extremes
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.entry_count == '0 |-> result.smallest == '0 && result.largest == '0)
    else $error("empty table with nonzero extremes");

  // a miss removes nothing
  a_miss_none: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_NOT_FOUND |-> result.removed_count == '0)
    else $error("not found but entries removed");

endmodule

bind sorted_value_table svt_checker u_svt_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .result  (result)
);

/* test/sorted_value_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_value_table_tb: self-checking bench for the sorted value table
// Sends insert, remove and read requests with random gaps. Every request is
// run through a local predictor when it is accepted. Every result word is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_value_table_tb;
  import svt_pkg::*;

  localparam int RANDOM_REQUESTS = 800;
  localparam int STALL_LIMIT     = 2000;  // slowest request is a 64-copy remove-all
  localparam int TAIL_CYCLES     = 100;   // quiet time after the last result
  localparam int QUIET_TAIL      = 100;   // last requests are sent back to back

  // one request waiting to be sent, with the idle gap that goes before it
  typedef struct {
    req_t word;
    int   gap;
    bit   drain;  // hold the word until every reply has come back
  } pending_request_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  req_t    request = '0;
  logic    done;
  result_t result;

  pending_request_t queued_requests[$];
  result_t          pending_replies[$];
  value_t           recent_values[$];

  // predictor state: ascending values and how many are valid
  value_t stored_values[DEPTH];
  int     stored_fill = 0;
  int     peak_fill = 0;

  // driver state
  bit     word_loaded = 1'b0;
  int     gap_left = 0;
  logic   next_start;

  // monitor and bookkeeping
  int     error_count = 0;
  int     replies_seen = 0;
  int     quiet_cycles = 0;
  bit     stalled = 1'b0;
  int     kind_seen[4] = '{0, 0, 0, 0};
  int     status_seen[4] = '{0, 0, 0, 0};

  sorted_value_table DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  // 20 ns clock period
  always #10 clk = ~clk;

  // apply one request to the local table and return the reply it should get
  function automatic result_t predict_reply(input req_t r);
    result_t reply;
    int      slot;
    int      keep;
    int      removed;
    int      i;
    reply = '0;
    reply.status = ST_OK;
    removed = 0;
    case (req_e'(r.req_type))
      REQ_INSERT: begin
        if (stored_fill >= DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          // new value goes in front of the first entry that is not smaller
          slot = 0;
          while (slot < stored_fill && stored_values[slot] < r.value) slot++;
          for (i = stored_fill; i > slot; i--) stored_values[i] = stored_values[i-1];
          stored_values[slot] = r.value;
          stored_fill++;
        end
      end
      REQ_REMOVE_ONE: begin
        slot = 0;
        while (slot < stored_fill && stored_values[slot] != r.value) slot++;
        if (slot < stored_fill) begin
          for (i = slot; i + 1 < stored_fill; i++) stored_values[i] = stored_values[i+1];
          stored_fill--;
          removed = 1;
        end else begin
          reply.status = ST_NOT_FOUND;
        end
      end
      REQ_REMOVE_ALL: begin
        // squeeze out every copy, keeping the rest in order
        keep = 0;
        for (i = 0; i < stored_fill; i++) begin
          if (stored_values[i] == r.value) removed++;
          else stored_values[keep++] = stored_values[i];
        end
        stored_fill = keep;
        if (removed == 0) reply.status = ST_NOT_FOUND;
      end
      REQ_READ: begin
        if (int'(r.position) < stored_fill) reply.read_value = stored_values[r.position];
        else reply.status = ST_RANGE;
      end
    endcase
    reply.removed_count = 7'(removed);
    reply.entry_count   = 7'(stored_fill);
    if (stored_fill > 0) begin
      reply.smallest = stored_values[0];
      reply.largest  = stored_values[stored_fill-1];
    end
    if (stored_fill > peak_fill) peak_fill = stored_fill;
    return reply;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic signed [63:0] got,
                             input logic signed [63:0] want);
    if (got !== want)
      report_error($sformatf("reply %0d: %s is %0d, expected %0d",
                             replies_seen, name, got, want));
  endtask

  // values: a small pool in four draws of ten, so that removes hit and duplicates pile up,
  // plus the extremes, recent inserts and fully random patterns
  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return value_t'($urandom_range(0, 8)) - 32'sd4;
      4: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7FFF_FFFF;
          2:       return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      5, 6: begin
        if (recent_values.size() > 0)
          return recent_values[$urandom_range(0, recent_values.size() - 1)];
        return value_t'($urandom());
      end
      default: return value_t'($urandom());
    endcase
  endfunction

  task automatic queue_item(input req_e kind, input value_t v, input logic [5:0] pos);
    pending_request_t item;
    item.word.req_type = kind;
    item.word.value    = v;
    item.word.position = pos;
    item.gap   = 0;
    item.drain = 1'b0;
    queued_requests.push_back(item);
    if (kind == REQ_INSERT) begin
      recent_values.push_back(v);
      if (recent_values.size() > 16) void'(recent_values.pop_front());
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: sends the front of the request queue, one word per handshake
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      request <= '0;
      word_loaded = 1'b0;
      gap_left = 0;
    end else begin
      next_start = 1'b0;
      // word taken at this edge: predict its reply and move on
      if (start && !busy) begin
        pending_replies.push_back(predict_reply(request));
        kind_seen[request.req_type]++;
        void'(queued_requests.pop_front());
        word_loaded = 1'b0;
      end
      if (!word_loaded && queued_requests.size() > 0) begin
        gap_left = queued_requests[0].gap;
        word_loaded = 1'b1;
      end
      if (word_loaded) begin
        // idle gap first, then a drain hold-off if this word asks for one
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(queued_requests[0].drain && pending_replies.size() > 0)) begin
          next_start = 1'b1;
        end
        request <= queued_requests[0].word;
      end
      // a single assignment per edge keeps start steady across back-to-back words
      start <= next_start;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: each done strobe carries one reply word; no stall is possible
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      // watchdog on cycles where no word moves in either direction
      if ((start && !busy) || done) quiet_cycles = 0;
      else if (quiet_cycles < STALL_LIMIT) quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) stalled = 1'b1;

      if (done) begin
        if (pending_replies.size() == 0) begin
          report_error($sformatf("reply %0d arrived with nothing outstanding", replies_seen));
        end else begin
          want = pending_replies.pop_front();
          check_field("status",        result.status,        want.status);
          check_field("read_value",    result.read_value,    want.read_value);
          check_field("removed_count", result.removed_count, want.removed_count);
          check_field("entry_count",   result.entry_count,   want.entry_count);
          check_field("smallest",      result.smallest,      want.smallest);
          check_field("largest",       result.largest,       want.largest);
        end
        if (!$isunknown(result.status)) status_seen[result.status]++;
        replies_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int   directed_count;
    int   random_count;
    int   episode;
    int   span;
    int   roll;
    bit   idle_on;
    req_e kind;

    // directed part: empty table, extremes, duplicates, emptying to zero
    queue_item(REQ_READ,       32'sd0,          6'd0);   // read of empty table
    queue_item(REQ_READ,       32'sd0,          6'd63);
    queue_item(REQ_REMOVE_ONE, 32'sd7,          6'd0);   // removes on empty table
    queue_item(REQ_REMOVE_ALL, 32'sd7,          6'd0);
    queue_item(REQ_INSERT,     32'sh7FFF_FFFF,  6'd0);
    queue_item(REQ_INSERT,     32'sh8000_0000,  6'd63);
    queue_item(REQ_INSERT,     32'sd0,          6'd0);
    queue_item(REQ_INSERT,     -32'sd1,         6'd0);
    queue_item(REQ_INSERT,     32'sd5,          6'd0);
    queue_item(REQ_INSERT,     32'sd5,          6'd0);   // duplicate
    queue_item(REQ_READ,       32'sd0,          6'd0);
    queue_item(REQ_READ,       32'sd0,          6'd5);   // last valid slot
    queue_item(REQ_READ,       32'sd0,          6'd6);   // position equal to count
    queue_item(REQ_READ,       32'sd0,          6'd63);
    queue_item(REQ_REMOVE_ONE, 32'sd9,          6'd0);   // absent value
    queue_item(REQ_REMOVE_ALL, 32'sd5,          6'd0);   // two copies go
    queue_item(REQ_REMOVE_ALL, 32'sd5,          6'd0);   // now absent
    queue_item(REQ_REMOVE_ONE, 32'sh8000_0000,  6'd0);   // smallest
    queue_item(REQ_REMOVE_ONE, 32'sh7FFF_FFFF,  6'd0);   // largest
    queue_item(REQ_REMOVE_ONE, -32'sd1,         6'd0);
    queue_item(REQ_REMOVE_ONE, 32'sd0,          6'd0);   // only entry left
    queue_item(REQ_REMOVE_ONE, 32'sd0,          6'd0);   // empty again
    queue_item(REQ_INSERT,     32'sd3,          6'd0);
    queue_item(REQ_INSERT,     32'sd3,          6'd0);
    queue_item(REQ_REMOVE_ONE, 32'sd3,          6'd0);   // one of two copies
    directed_count = queued_requests.size();

    // random part in episodes: fill toward full, mixed traffic, emptying
    random_count = 0;
    while (random_count < RANDOM_REQUESTS) begin
      episode = (random_count == 0) ? 0 : $urandom_range(0, 3);
      if (episode == 0)      span = $urandom_range(60, 72);
      else if (episode == 3) span = $urandom_range(10, 20);
      else                   span = $urandom_range(20, 60);
      repeat (span) begin
        roll = $urandom_range(0, 99);
        if (episode == 0) begin
          if (roll < 88)      kind = REQ_INSERT;
          else if (roll < 96) kind = REQ_READ;
          else                kind = REQ_REMOVE_ONE;
        end else if (episode == 3) begin
          if (roll < 60)      kind = REQ_REMOVE_ALL;
          else if (roll < 85) kind = REQ_REMOVE_ONE;
          else                kind = REQ_READ;
        end else begin
          if (roll < 35)      kind = REQ_INSERT;
          else if (roll < 55) kind = REQ_REMOVE_ONE;
          else if (roll < 65) kind = REQ_REMOVE_ALL;
          else                kind = REQ_READ;
        end
        queue_item(kind, pick_value(),
                   $urandom_range(0, 1) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 7)));
        random_count++;
      end
    end

    // idle bursts in stretches, none in the closing part of the run
    idle_on = 1'b1;
    foreach (queued_requests[i]) begin
      if (i % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (idle_on && i < queued_requests.size() - QUIET_TAIL && $urandom_range(0, 3) == 0)
        queued_requests[i].gap = $urandom_range(1, 12);
    end
    // let the table settle completely before the random part and mid-run
    queued_requests[directed_count].drain = 1'b1;
    queued_requests[queued_requests.size() / 2].drain = 1'b1;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (!stalled && (queued_requests.size() != 0 || pending_replies.size() != 0))
      @(posedge clk);
    if (!stalled) repeat (TAIL_CYCLES) @(posedge clk);

    if (stalled)
      report_error($sformatf("no word moved for %0d cycles", STALL_LIMIT));
    if (pending_replies.size() != 0)
      report_error($sformatf("%0d replies never arrived", pending_replies.size()));

    $display("run: %0d inserts, %0d single removes, %0d bulk removes, %0d reads; peak fill %0d",
             kind_seen[REQ_INSERT], kind_seen[REQ_REMOVE_ONE], kind_seen[REQ_REMOVE_ALL],
             kind_seen[REQ_READ], peak_fill);
    $display("replies: %0d ok, %0d full, %0d not found, %0d out of range, %0d errors",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NOT_FOUND],
             status_seen[ST_RANGE], error_count);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
